// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold whenever ante holds
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cfp_pkg.sv -----
package cfp_pkg;

  localparam logic [7:0]  START_BYTE     = 8'hCA;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd2048;

  // parser phase codes
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_OP   = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4
  } cfp_phase_t;

  // frame status codes
  typedef enum logic [1:0] {
    STAT_NONE = 2'd0,
    STAT_GOOD = 2'd1,
    STAT_BAD  = 2'd2
  } cfp_status_t;

  // one result beat
  typedef struct packed {
    logic        payload_valid;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    cfp_status_t frame_status;
    logic [15:0] frame_length;
    logic [7:0]  frame_opcode;
  } cfp_result_t;

endpackage

// ----- src/cfp_ifs.sv -----
// received byte channel
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// parser result channel
interface cfp_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [15:0] payload_index;
  logic [7:0]  payload_byte;
  logic [1:0]  frame_status;
  logic [15:0] frame_length;
  logic [7:0]  frame_opcode;

  modport source (output valid, output payload_valid, output payload_index,
                  output payload_byte, output frame_status, output frame_length,
                  output frame_opcode, input ready);
  modport sink (input valid, input payload_valid, input payload_index,
                input payload_byte, input frame_status, input frame_length,
                input frame_opcode, output ready);
endinterface

// ----- src/cfp_in_stage.sv -----
module cfp_in_stage
  import cfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cfp_in_if.sink     in_ch,
  input  logic       take,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       load;

  // stage frees up when empty or when its beat moves on
  assign load        = !valid_r || take;
  assign in_ch.ready = load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_ch.valid) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

// ----- src/cfp_parse.sv -----
module cfp_parse
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  logic [7:0]  s1_byte,
  output logic        take,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  cfp_out_if.source   out_ch
);

  cfp_phase_t  phase_r, phase_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  opc_r, opc_nxt;
  logic [15:0] max_len_r;
  logic        out_valid_r;
  cfp_result_t res_r, res_nxt;
  logic        step;
  logic [15:0] cnt_inc;

  // result register can load when empty or being drained
  assign take    = !out_valid_r || out_ch.ready;
  assign step    = s1_valid && take;
  assign cnt_inc = cnt_r + 16'd1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_r <= cfg_data;
    end
  end

  // parser state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      plen_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      opc_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      plen_r  <= plen_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      opc_r   <= opc_nxt;
    end
  end

  // next state and result for one byte
  always_comb begin
    phase_nxt = phase_r;
    plen_nxt  = plen_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    opc_nxt   = opc_r;
    res_nxt   = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (s1_byte == START_BYTE) begin
          phase_nxt = PH_LEN;
          plen_nxt  = '0;
          cnt_nxt   = '0;
          sum_nxt   = '0;
        end
      end
      PH_LEN: begin
        // length arrives low byte first
        if (cnt_r == '0) begin
          plen_nxt = {plen_r[15:8], s1_byte};
          cnt_nxt  = 16'd1;
        end else begin
          plen_nxt  = {s1_byte, plen_r[7:0]};
          cnt_nxt   = '0;
          phase_nxt = PH_OP;
        end
      end
      PH_OP: begin
        opc_nxt   = s1_byte;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        // empty or oversized frame is abandoned and this byte dropped
        if (cnt_r >= plen_r || plen_r > max_len_r) begin
          phase_nxt = PH_HUNT;
        end else begin
          sum_nxt               = sum_r + s1_byte;
          res_nxt.payload_valid = 1'b1;
          res_nxt.payload_index = cnt_r;
          res_nxt.payload_byte  = s1_byte;
          cnt_nxt               = cnt_inc;
          if (cnt_inc == plen_r) begin
            phase_nxt = PH_SUM;
          end
        end
      end
      PH_SUM: begin
        phase_nxt = PH_HUNT;
        if (sum_r == s1_byte) begin
          res_nxt.frame_status = STAT_GOOD;
          res_nxt.frame_length = plen_r;
          res_nxt.frame_opcode = opc_r;
        end else begin
          res_nxt.frame_status = STAT_BAD;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.payload_index = res_r.payload_index;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.frame_status  = res_r.frame_status;
  assign out_ch.frame_length  = res_r.frame_length;
  assign out_ch.frame_opcode  = res_r.frame_opcode;

endmodule

// ----- src/config_frame_parser_core.sv -----
// each byte goes into the input register, then through the parse logic into the
// result register, from which its result beat is taken
// throughput: one byte per cycle while the result side does not stall, one result beat per byte
// a stalled result holds while one more byte waits in the input register
// reset (rst_n low, synchronous): parser hunts for a start byte, max_length = 2048
module config_frame_parser_core
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cfp_in_if.sink      in_ch,
  cfp_out_if.source   out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_length
);

  logic       take;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       cfg_wr;

  // configuration beats are always taken
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  cfp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  cfp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .take     (take),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_max_length),
    .out_ch   (out_ch)
  );

endmodule

// ----- src/cfp_checker.sv -----
`include "assert_macros.svh"

module cfp_checker
  import cfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        payload_valid,
  input logic [15:0] payload_index,
  input logic [1:0]  frame_status
);

  // a stalled result beat stays up
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

  // a payload byte and a frame report never share a beat
  `ASSERT_IMPLY(a_excl, clk, rst_n, out_valid && payload_valid, frame_status == STAT_NONE, "payload byte and frame status in one beat")

  // only defined status codes appear
  `ASSERT_IMPLY(a_status, clk, rst_n, out_valid, frame_status == STAT_NONE || frame_status == STAT_GOOD || frame_status == STAT_BAD, "undefined frame status")

  // consecutive payload beats count up by one
  `ASSERT_IMPLY(a_index, clk, rst_n, out_valid && payload_valid && payload_index != 16'd0 && $past(out_valid && out_ready), $past(payload_valid) && payload_index == $past(payload_index) + 16'd1, "payload index not contiguous")

endmodule

bind config_frame_parser_core cfp_checker u_cfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_valid (out_ch.payload_valid),
  .payload_index (out_ch.payload_index),
  .frame_status  (out_ch.frame_status)
);

// ----- test/config_frame_parser_core_tb.sv -----
`timescale 1ns / 1ps

module config_frame_parser_core_tb;
  import cfp_pkg::*;

  localparam int PIPE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 2000;
  localparam int ITEMS_PER_SETTING = 190;
  localparam int PRESSURE_STALL = 200;

  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    cfp_result_t want;
  } dir_row_t;

  typedef struct {
    bit          typed;
    cfp_result_t want;
  } row_hint_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_max_length;

  cfp_in_if  in_ch();
  cfp_out_if out_ch();

  config_frame_parser_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_max_length(cfg_max_length)
  );

  always #5 clk = ~clk;

  // parser state as this bench sees it
  cfp_phase_t  ps_phase;
  logic [15:0] ps_len;
  logic [15:0] ps_count;
  logic [7:0]  ps_sum;
  logic [7:0]  ps_opcode;
  logic [15:0] max_len_cfg;

  cfp_result_t expected_beats[$];
  row_hint_t   row_hints[$];
  dir_row_t    rows[$];

  bit pressure_done = 1'b0;
  int fail_count = 0;
  int bytes_sent = 0;
  int beats_seen = 0;
  int payload_beats = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int cfg_writes = 0;

  // advance the parser by one received byte and return its result beat
  function automatic cfp_result_t parse_byte(input logic [7:0] b);
    cfp_result_t r;
    r = '0;
    case (ps_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          ps_phase = PH_LEN;
          ps_len   = '0;
          ps_count = '0;
          ps_sum   = '0;
        end
      end
      PH_LEN: begin
        if (ps_count == 16'd0) begin
          ps_len[7:0] = b;
          ps_count    = 16'd1;
        end else begin
          ps_len[15:8] = b;
          ps_count     = '0;
          ps_phase     = PH_OP;
        end
      end
      PH_OP: begin
        ps_opcode = b;
        ps_phase  = PH_DATA;
      end
      PH_DATA: begin
        // zero or oversized length: drop the byte and hunt again
        if (ps_count >= ps_len || ps_len > max_len_cfg) begin
          ps_phase = PH_HUNT;
        end else begin
          ps_sum          = ps_sum + b;
          r.payload_valid = 1'b1;
          r.payload_index = ps_count;
          r.payload_byte  = b;
          ps_count        = ps_count + 16'd1;
          if (ps_count == ps_len) ps_phase = PH_SUM;
        end
      end
      PH_SUM: begin
        ps_phase = PH_HUNT;
        if (ps_sum == b) begin
          r.frame_status = STAT_GOOD;
          r.frame_length = ps_len;
          r.frame_opcode = ps_opcode;
        end else begin
          r.frame_status = STAT_BAD;
        end
      end
      default: ps_phase = PH_HUNT;
    endcase
    return r;
  endfunction

  function automatic cfp_result_t beat(input logic v, input logic [15:0] idx,
                                       input logic [7:0] pb, input cfp_status_t st,
                                       input logic [15:0] len, input logic [7:0] op);
    cfp_result_t r;
    r.payload_valid = v;
    r.payload_index = idx;
    r.payload_byte  = pb;
    r.frame_status  = st;
    r.frame_length  = len;
    r.frame_opcode  = op;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // frame length: zero, oversized, exactly the limit, or a short legal one
  function automatic logic [15:0] pick_length();
    int r;
    int top;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (max_len_cfg != 16'hFFFF && (r < 20 || max_len_cfg == 16'd0))
      return 16'($urandom_range(int'(max_len_cfg) + 1, 65535));
    if (r < 28 && max_len_cfg <= 16'd64) return max_len_cfg;
    top = (max_len_cfg < 16'd24) ? int'(max_len_cfg) : 24;
    return 16'($urandom_range(1, top));
  endfunction

  // one byte beat on the input channel
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // start byte, length, opcode, then payload and checksum or one dropped byte
  task automatic send_frame(input logic [15:0] len, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] pb;
    sum = '0;
    send_byte(START_BYTE);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(8'($urandom_range(0, 255)));
    if (len == 16'd0 || len > max_len_cfg) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < int'(len); i++) begin
        pb = ($urandom_range(0, 9) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
        sum = sum + pb;
        send_byte(pb);
      end
      send_byte(good_sum ? sum : 8'($urandom_range(0, 255)));
    end
  endtask

  // stop sending and wait for every expected beat to come back
  task automatic drain_beats();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_beats.size());
      fail_count += expected_beats.size();
      expected_beats.delete();
    end
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_max_length <= v;
    do @(posedge clk); while (!cfg_ready);
    max_len_cfg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] rx, input bit typed, input cfp_result_t want);
    dir_row_t row;
    row.rx    = rx;
    row.typed = typed;
    row.want  = want;
    rows.push_back(row);
  endtask

  // predict on every accepted byte beat
  always @(posedge clk) begin
    cfp_result_t predicted;
    row_hint_t   hint;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predicted = parse_byte(in_ch.rx_byte);
      if (row_hints.size() != 0) begin
        hint = row_hints.pop_front();
        if (hint.typed) predicted = hint.want;
      end
      expected_beats.push_back(predicted);
    end
  end

  // compare every accepted result beat with the oldest expectation
  always @(posedge clk) begin
    cfp_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("result beat arrived with nothing expected");
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("payload_valid", want.payload_valid, out_ch.payload_valid);
        check_field("payload_index", want.payload_index, out_ch.payload_index);
        check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
        check_field("frame_status", want.frame_status, out_ch.frame_status);
        check_field("frame_length", want.frame_length, out_ch.frame_length);
        check_field("frame_opcode", want.frame_opcode, out_ch.frame_opcode);
      end
      if (out_ch.payload_valid) payload_beats++;
      if (out_ch.frame_status == STAT_GOOD) good_frames++;
      if (out_ch.frame_status == STAT_BAD) bad_frames++;
    end
  end

  // result side stalls, with one long hold-off while bytes keep coming
  initial begin
    int run_len;
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      run_len = $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (run_len) @(negedge clk);
      stall = pick_gap();
      if (!pressure_done && beats_seen >= 300 && in_ch.valid) begin
        stall = PRESSURE_STALL;
        pressure_done = 1'b1;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // run limit
  initial begin
    #(50_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    cfp_result_t idle;
    row_hint_t   hint;
    logic [15:0] limits[7];
    logic [7:0]  nb;
    int          phase_start;
    int          noise_n;

    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    cfg_valid      = 1'b0;
    cfg_max_length = '0;

    max_len_cfg = MAX_LEN_RESET;
    ps_phase    = PH_HUNT;
    ps_len      = '0;
    ps_count    = '0;
    ps_sum      = '0;
    ps_opcode   = '0;

    idle = beat(1'b0, 16'd0, 8'd0, STAT_NONE, 16'd0, 8'd0);

    // noise while hunting, then a one-byte frame at the byte extremes
    add_row(8'h00, 1'b1, idle);
    add_row(8'hFF, 1'b1, idle);
    add_row(START_BYTE, 1'b1, idle);
    add_row(8'h01, 1'b1, idle);
    add_row(8'h00, 1'b1, idle);
    add_row(8'hFF, 1'b1, idle);
    add_row(8'hFF, 1'b1, beat(1'b1, 16'd0, 8'hFF, STAT_NONE, 16'd0, 8'd0));
    add_row(8'hFF, 1'b1, beat(1'b0, 16'd0, 8'd0, STAT_GOOD, 16'd1, 8'hFF));
    // start byte as opcode, then a checksum mismatch
    add_row(START_BYTE, 1'b0, idle);
    add_row(8'h02, 1'b0, idle);
    add_row(8'h00, 1'b0, idle);
    add_row(START_BYTE, 1'b0, idle);
    add_row(8'h80, 1'b0, idle);
    add_row(8'h7F, 1'b0, idle);
    add_row(8'h00, 1'b1, beat(1'b0, 16'd0, 8'd0, STAT_BAD, 16'd0, 8'd0));
    // zero length: the start byte in the data slot is dropped, not taken as start
    add_row(START_BYTE, 1'b1, idle);
    add_row(8'h00, 1'b1, idle);
    add_row(8'h00, 1'b1, idle);
    add_row(8'h55, 1'b1, idle);
    add_row(START_BYTE, 1'b1, idle);
    // length one above the reset limit
    add_row(START_BYTE, 1'b1, idle);
    add_row(8'h01, 1'b1, idle);
    add_row(8'h08, 1'b1, idle);
    add_row(8'h00, 1'b1, idle);
    add_row(8'h33, 1'b1, idle);
    add_row(8'h12, 1'b1, idle);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset limit
    foreach (rows[i]) begin
      hint.typed = rows[i].typed;
      hint.want  = rows[i].want;
      row_hints.push_back(hint);
      send_byte(rows[i].rx);
    end
    drain_beats();

    limits[0] = 16'd0;
    limits[1] = 16'd1;
    limits[2] = 16'd16;
    limits[3] = 16'hFFFF;
    limits[4] = 16'($urandom_range(2, 255));
    limits[5] = 16'd200;
    limits[6] = MAX_LEN_RESET;

    foreach (limits[k]) begin
      write_max_length(limits[k]);

      // mostly well-formed frames, the rest short bursts of noise
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < ITEMS_PER_SETTING) begin
        if ($urandom_range(0, 99) < 75) begin
          send_frame(pick_length(), $urandom_range(0, 9) < 7);
        end else begin
          noise_n = $urandom_range(1, 6);
          repeat (noise_n) begin
            nb = 8'($urandom_range(0, 255));
            // keep stray starts away from long legal lengths
            if (max_len_cfg > 16'd255 && nb == START_BYTE) nb = 8'h00;
            send_byte(nb);
          end
        end
      end
      drain_beats();

      // bring the parser back to hunting before the limit changes
      while (ps_phase != PH_HUNT) begin
        send_byte(8'h00);
        drain_beats();
      end
    end

    $display("covered %0d bytes under %0d max_length settings from 0 to 65535",
             bytes_sent, cfg_writes + 1);
    $display("checked %0d beats: %0d payload bytes, %0d good and %0d bad frames",
             beats_seen, payload_beats, good_frames, bad_frames);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/cfp_pkg.sv
src/cfp_ifs.sv
src/cfp_in_stage.sv
src/cfp_parse.sv
src/config_frame_parser_core.sv
src/cfp_checker.sv
test/config_frame_parser_core_tb.sv
